### sv/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Payload types, round constants and initial hash values.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       wr_byte;     // write wr_data at wr_addr
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       start;       // load working vars, round 0
    logic       round;       // advance one round
    logic       finish;      // add working vars into hash
    logic       init;        // reload initial hash
  } dp_cmd_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMarker = 8'h80;

endpackage

### sv/sha256_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block bytes written in place into the 16-word rolling schedule, one
// compression round per cycle.
// ----------------------------------------------------------------------------
module sha256_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256_pkg::dp_cmd_t cmd_i,
  input  logic [5:0]          round_idx_i,
  input  logic [2:0]          hash_sel_i,
  output logic [31:0]         hash_word_o
);

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  logic [31:0] w_q [16];
  logic [31:0] r_q [8];
  logic [31:0] hash_q [8];

  logic [31:0] w_cur, w_new, x, y, s0, s1;
  logic [31:0] big1, ch, t1, big0, maj, t2;

  always_comb begin
    x     = w_q[1];
    y     = w_q[14];
    s0    = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    s1    = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    w_cur = w_q[0];
    big1  = rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25);
    ch    = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
    t1    = r_q[7] + big1 + ch + sha256_pkg::RoundK[round_idx_i] + w_cur;
    big0  = rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22);
    maj   = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
    t2    = big0 + maj;
  end

  // Schedule words double as the block buffer: bytes land big-endian in
  // place, and every byte of a block is rewritten before its rounds start.
  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end else begin
      if (cmd_i.wr_byte) begin
        w_q[cmd_i.wr_addr[5:2]][{~cmd_i.wr_addr[1:0], 3'b000} +: 8] <= cmd_i.wr_data;
      end
      if (cmd_i.start) begin
        for (int i = 0; i < 8; i++) r_q[i] <= hash_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
    end else if (cmd_i.init) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
    end else if (cmd_i.finish) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + r_q[i];
    end
  end

  assign hash_word_o = hash_q[hash_sel_i];

endmodule

### sv/sha256_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Byte intake, padding sequencer, round counter and digest output register.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sha256_pkg::in_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sha256_pkg::out_item_t  out_data_o,
  output sha256_pkg::dp_cmd_t    cmd_o,
  output logic [5:0]             round_idx_o,
  output logic [2:0]             hash_sel_o,
  input  logic [31:0]            hash_word_i
);

  typedef enum logic [2:0] {
    StIdle, StRound, StAdd, StPadZero, StPadLen, StEmit
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] count_q, count_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        ending_q, ending_d;   // message end pending
  logic        padding_q, padding_d; // message finishing, digest not emitted
  logic        last_q, last_d;       // compression in flight is the final one
  logic [2:0]  sel_q, sel_d;
  logic        ov_q, ov_d;
  sha256_pkg::out_item_t od_q, od_d;
  logic [63:0] len_bits;
  logic        take;

  assign in_ready_o  = (state_q == StIdle);
  assign take        = in_valid_i && in_ready_o;
  assign len_bits    = {count_q, 3'b000};
  assign round_idx_o = rnd_q;
  assign hash_sel_o  = sel_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    count_d   = count_q;
    rnd_d     = rnd_q;
    ending_d  = ending_q;
    padding_d = padding_q;
    last_d    = last_q;
    sel_d     = sel_q;
    ov_d      = ov_q;
    od_d      = od_q;
    cmd_o     = '0;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          ending_d  = in_data_i.message_end;
          padding_d = in_data_i.message_end;
          if (in_data_i.byte_present) begin
            cmd_o.wr_byte = 1'b1;
            cmd_o.wr_addr = fill_q;
            cmd_o.wr_data = in_data_i.data_byte;
            fill_d        = fill_q + 6'd1;
            count_d       = count_q + 61'd1;
            if (fill_q == 6'd63) begin
              cmd_o.start = 1'b1;
              last_d      = 1'b0;
              rnd_d       = '0;
              state_d     = StRound;
            end else if (in_data_i.message_end) begin
              state_d = StPadZero;
              fill_d  = fill_q + 6'd1;
            end
          end else if (in_data_i.message_end) begin
            state_d = StPadZero;
          end
          // Marker goes in on first pad cycle; fill_d marks its slot.
        end
      end
      StPadZero: begin
        // First visit: marker at fill_q; zeros to byte 55, or 63 then 0..55.
        cmd_o.wr_byte = 1'b1;
        cmd_o.wr_addr = fill_q;
        cmd_o.wr_data = ending_q ? sha256_pkg::PadMarker : 8'h00;
        ending_d      = 1'b0;
        fill_d        = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          cmd_o.start = 1'b1;
          last_d      = 1'b0;
          rnd_d       = '0;
          state_d     = StRound;
        end else if (fill_q == 6'd55) begin
          state_d = StPadLen;
        end
      end
      StPadLen: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.wr_addr = fill_q;
        cmd_o.wr_data = len_bits[8*(6'd63 - fill_q) +: 8];
        fill_d        = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          cmd_o.start = 1'b1;
          last_d      = 1'b1;
          rnd_d       = '0;
          state_d     = StRound;
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = StAdd;
      end
      StAdd: begin
        cmd_o.finish = 1'b1;
        if (last_q) begin
          sel_d   = '0;
          state_d = StEmit;
        end else if (padding_q) begin
          // Padding still to do (marker pending, or zeros and length remain).
          state_d = StPadZero;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (!ov_q || out_ready_i) begin
          ov_d             = 1'b1;
          od_d.digest_word = hash_word_i;
          od_d.word_index  = sel_q;
          od_d.last_word   = (sel_q == 3'd7);
          sel_d            = sel_q + 3'd1;
          if (sel_q == 3'd7) begin
            cmd_o.init = 1'b1;
            fill_d     = '0;
            count_d    = '0;
            padding_d  = 1'b0;
            state_d    = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q != StEmit && ov_q && out_ready_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      count_q   <= '0;
      rnd_q     <= '0;
      ending_q  <= 1'b0;
      padding_q <= 1'b0;
      last_q    <= 1'b0;
      sel_q     <= '0;
      ov_q      <= 1'b0;
      od_q      <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      rnd_q     <= rnd_d;
      ending_q  <= ending_d;
      padding_q <= padding_d;
      last_q    <= last_d;
      sel_q     <= sel_d;
      ov_q      <= ov_d;
      od_q      <= od_d;
    end
  end

endmodule

### sv/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream; emits the eight digest words on message end.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | in_data_i  (byte, present, end)
// out     | output    | out_valid_o/out_ready_i| out_data_o (word, index, last)
//
// A byte that neither fills the block nor ends the message keeps intake
// ready. The 64th byte of a block starts the compression: rounds in the
// single round unit, then an add. Message end writes padding one byte per
// cycle, pausing to compress a full block (one or two compressions in all);
// then eight digest words leave through one output register (one per cycle
// when the sink takes them). Input is held off while any of this runs.
// Reset loads the initial hash and clears counts; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_item_t out_data_o
);

  sha256_pkg::dp_cmd_t cmd;
  logic [5:0]          round_idx;
  logic [2:0]          hash_sel;
  logic [31:0]         hash_word;

  // Sequence intake, padding, rounds and digest output.
  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .round_idx_o (round_idx),
    .hash_sel_o  (hash_sel),
    .hash_word_i (hash_word)
  );

  // Hold the block, schedule and hash state; run one round per cycle.
  sha256_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .round_idx_i (round_idx),
    .hash_sel_i  (hash_sel),
    .hash_word_o (hash_word)
  );

endmodule
